/* hw/rtl/pbn_pkg.sv */
// pbn_pkg: shared types, event codes and panel step table for the
// panel brightness / night controller; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pbn_pkg;

   localparam int unsigned TimeWidth      = 32;
   localparam logic [TimeWidth-1:0] IdleThresholdReset = 32'd259200000;

   localparam logic [2:0] LVL_DIM   = 3'd0;
   localparam logic [2:0] LVL_FULL  = 3'd3;
   localparam logic [2:0] LVL_NIGHT = 3'd4;

   typedef enum logic [3:0] {
      OP_TICK      = 4'd0,
      OP_SET_LEVEL = 4'd1,
      OP_CYCLE     = 4'd2,
      OP_NIGHT_ON  = 4'd3,
      OP_NIGHT_OFF = 4'd4,
      OP_AUTO      = 4'd5,
      OP_ALARM_ON  = 4'd6,
      OP_ALARM_OFF = 4'd7,
      OP_USER      = 4'd8
   } op_type;

   typedef struct packed {
      logic [3:0]           opcode;
      logic [TimeWidth-1:0] now_ms;
      logic [2:0]           level_request;
      logic                 enable_flag;
   } item_type;

   typedef struct packed {
      logic       save_pulse;
      logic       redraw_pulse;
      logic       apply_pulse;
      logic [7:0] vcomh_byte;
      logic [7:0] precharge_byte;
      logic [7:0] contrast_byte;
      logic       idle_on;
      logic       night_on;
      logic [2:0] level_now;
   } result_type;

   function automatic logic [7:0] step_contrast(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h00;
         2'd1:    val = 8'h20;
         2'd2:    val = 8'h80;
         default: val = 8'hFF;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] step_precharge(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h11;
         2'd1:    val = 8'h22;
         2'd2:    val = 8'h44;
         default: val = 8'hF1;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] step_vcomh(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h00;
         2'd1:    val = 8'h20;
         2'd2:    val = 8'h30;
         default: val = 8'h40;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/pbn_event_unit.sv */
// pbn_event_unit: level / alarm / idle state registers and the combinational
// event logic that updates them and forms the result; uses pbn_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbn_event_unit
   import pbn_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire item_type             item,
   input  wire logic [TimeWidth-1:0] idle_threshold,
   output      result_type           result
);

   logic [2:0]           cur_ff,  cur_in;
   logic [1:0]           day_ff,  day_in;
   logic                 rp_ff,   rp_in;
   logic [2:0]           rt_ff,   rt_in;
   logic                 idle_ff, idle_in;
   logic                 ibn_ff,  ibn_in;
   logic [TimeWidth-1:0] last_ff, last_in;

   logic [TimeWidth-1:0] elapsed;
   logic          do_set, do_enter, do_exit;
   logic [2:0]    set_val, clamped;
   logic          apply, redraw, save;
   logic [1:0]    idx;

   assign elapsed = item.now_ms - last_ff;

   always_comb begin
      cur_in   = cur_ff;
      day_in   = day_ff;
      rp_in    = rp_ff;
      rt_in    = rt_ff;
      idle_in  = idle_ff;
      ibn_in   = ibn_ff;
      last_in  = last_ff;
      do_set   = 1'b0;
      do_enter = 1'b0;
      do_exit  = 1'b0;
      set_val  = LVL_FULL;
      clamped  = LVL_FULL;
      apply    = 1'b0;
      redraw   = 1'b0;
      save     = 1'b0;

      case (op_type'(item.opcode))
         OP_TICK: begin
            if (!idle_ff && elapsed >= idle_threshold) begin
               idle_in  = 1'b1;
               ibn_in   = (cur_ff == LVL_NIGHT);
               do_enter = (cur_ff != LVL_NIGHT);
            end
         end
         OP_SET_LEVEL: begin
            do_set  = 1'b1;
            set_val = item.level_request;
         end
         OP_CYCLE: begin
            do_set  = 1'b1;
            set_val = (cur_ff == LVL_NIGHT) ? LVL_DIM : cur_ff + 3'd1;
            save    = 1'b1;
         end
         OP_NIGHT_ON:  do_enter = 1'b1;
         OP_NIGHT_OFF: do_exit  = 1'b1;
         OP_AUTO:      do_exit  = !item.enable_flag;
         OP_ALARM_ON: begin
            if (!rp_ff) begin
               rp_in = 1'b1;
               rt_in = (cur_ff == LVL_NIGHT) ? {1'b0, day_ff} : cur_ff;
            end
            do_set  = 1'b1;
            set_val = LVL_FULL;
         end
         OP_ALARM_OFF: begin
            if (rp_ff) begin
               rp_in   = 1'b0;
               do_set  = 1'b1;
               set_val = rt_ff;
            end
         end
         OP_USER: begin
            last_in = item.now_ms;
            if (idle_ff) begin
               idle_in = 1'b0;
               do_exit = !ibn_ff;
               redraw  = 1'b1;
            end
         end
         default: ;
      endcase

      // night transitions while an alarm holds the panel only retarget the restore
      if (do_enter) begin
         if (rp_ff) begin
            rt_in = LVL_NIGHT;
         end else begin
            do_set  = 1'b1;
            set_val = LVL_NIGHT;
         end
      end
      if (do_exit) begin
         if (rp_ff) begin
            rt_in = {1'b0, day_ff};
         end else if (cur_ff == LVL_NIGHT) begin
            do_set  = 1'b1;
            set_val = {1'b0, day_ff};
         end
      end

      if (do_set) begin
         clamped = (set_val > LVL_NIGHT) ? LVL_FULL : set_val;
         cur_in  = clamped;
         if (clamped != LVL_NIGHT) begin
            day_in = clamped[1:0];
         end
         apply  = 1'b1;
         redraw = 1'b1;
      end
   end

   assign idx = (cur_in == LVL_NIGHT) ? 2'd0 : cur_in[1:0];

   always_comb begin
      result.level_now      = cur_in;
      result.night_on       = (cur_in == LVL_NIGHT);
      result.idle_on        = idle_in;
      result.contrast_byte  = step_contrast(idx);
      result.precharge_byte = step_precharge(idx);
      result.vcomh_byte     = step_vcomh(idx);
      result.apply_pulse    = apply;
      result.redraw_pulse   = redraw;
      result.save_pulse     = save;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= LVL_FULL;
         day_ff  <= LVL_FULL[1:0];
         rp_ff   <= 1'b0;
         rt_ff   <= LVL_DIM;
         idle_ff <= 1'b0;
         ibn_ff  <= 1'b0;
         last_ff <= '0;
      end else if (fire) begin
         cur_ff  <= cur_in;
         day_ff  <= day_in;
         rp_ff   <= rp_in;
         rt_ff   <= rt_in;
         idle_ff <= idle_in;
         ibn_ff  <= ibn_in;
         last_ff <= last_in;
      end
   end

   level_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= LVL_NIGHT && rt_ff <= LVL_NIGHT)
      else $error("panel level out of range");

   idle_night_origin: assert property (@(posedge clock) disable iff (reset)
      fire && !idle_ff && idle_in && !ibn_in && !rp_ff |-> cur_in == LVL_NIGHT)
      else $error("idle start did not dim to night");

   alarm_forces_full: assert property (@(posedge clock) disable iff (reset)
      fire && item.opcode == OP_ALARM_ON |-> cur_in == LVL_FULL && rp_in)
      else $error("alarm start did not take the panel to full");

endmodule

`default_nettype wire

/* hw/rtl/panel_brightness_night_controller.sv */
// panel_brightness_night_controller: top level with stream ports, input
// register, idle threshold register and result register; uses pbn_pkg and
// pbn_event_unit
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  req     | in  | tvalid / tready    | tuser opcode, tdata time/level/enable
//  rsp     | out | tvalid / tready    | tdata level, flags, panel bytes, pulses
//  csr     | in  | write enable only  | idle threshold in ms
//
// one item per cycle sustained while the rsp side is not stalled; an item is held in
// the input register, its event logic runs against the state registers in a single
// pass, and the result is captured in the result register
// the input register refills in the same cycle the result register is taken,
// so a stalled rsp side only holds back req once both registers are full
// synchronous reset: state back to full level, no alarm, not idle, threshold
// 259200000 ms; both item registers empty
`timescale 1ns / 1ps
`default_nettype none

module panel_brightness_night_controller
   import pbn_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [39:0]          req_tdata,   // now_ms[31:0], level_request[34:32],
                                                  // enable_flag[35], zero[39:36]
   input  wire logic [3:0]           req_tuser,   // opcode[3:0]
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [31:0]          rsp_tdata,   // level_now[2:0], night_on[3], idle_on[4],
                                                  // contrast_byte[12:5], precharge_byte[20:13],
                                                  // vcomh_byte[28:21], apply_pulse[29],
                                                  // redraw_pulse[30], save_pulse[31]
   input  wire logic                 csr_we,
   input  wire logic [TimeWidth-1:0] csr_wdata
);

   logic                 in_valid_ff, in_valid_in;
   item_type             in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_res_ff;
   logic [TimeWidth-1:0] thr_ff;
   result_type           step_res;
   logic                 fire;

   // the held item moves on when the result slot is free or being emptied
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         thr_ff       <= IdleThresholdReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.opcode        <= req_tuser;
         in_item_ff.now_ms        <= req_tdata[31:0];
         in_item_ff.level_request <= req_tdata[34:32];
         in_item_ff.enable_flag   <= req_tdata[35];
      end
      if (fire) begin
         out_res_ff <= step_res;
      end
   end

   pbn_event_unit u_event (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .item           (in_item_ff),
      .idle_threshold (thr_ff),
      .result         (step_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff;

   night_flag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3] == (rsp_tdata[2:0] == LVL_NIGHT))
      else $error("night flag disagrees with level");

   save_needs_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31] |-> rsp_tdata[29] && rsp_tdata[30])
      else $error("save pulse without apply and redraw");

   no_fire_when_empty: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("result lost after event processed");

   held_result_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !fire)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
